// ===== hdl/ssu_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and codes of the substring search unit.
// Used by ssu_cell, ssu_out_buf, substring_search_unit and the testbench; depends on nothing.
package ssu_pkg;

	// Needle capacity and width of the haystack position counter.
	localparam int NEEDLE_MAX    = 64;
	localparam int POS_BITS      = 32;

	// Derived widths.
	localparam int LEN_W         = $clog2(NEEDLE_MAX + 1);
	localparam int WIDE_W        = POS_BITS + 1;
	localparam int BYTE_W        = 8;
	localparam int MATCH_POS_W   = 32;

	// Item kinds carried on the input tuser.
	localparam logic MODE_NEEDLE = 1'b0;
	localparam logic MODE_HAY    = 1'b1;

	// String terminator.
	localparam logic [BYTE_W-1:0] NUL_BYTE = 8'h00;

	// Broadcast control from the top level to every cell of the chain.
	typedef struct packed {
		logic              wr_en;     // store data at wr_idx
		logic [LEN_W-1:0]  wr_idx;    // needle slot being appended
		logic              step;      // advance partial matches on data
		logic              clr;       // drop all partial matches
		logic [LEN_W-1:0]  needle_len;
		logic [BYTE_W-1:0] data;
	} ssu_ctrl_t;

	// One result word.
	typedef struct packed {
		logic                   ovf;
		logic [MATCH_POS_W-1:0] pos;
		logic                   found;
	} ssu_result_t;

endpackage

// ===== hdl/substring_search_unit.sv =====
`timescale 1ns / 1ps
// A result word for the matching or terminating byte is registered in ssu_out_buf before
// it reaches the master side. Throughput: one word per cycle on both sides; the
// input stalls only when both output entries hold words the consumer has not taken.
// Reset (arst_n low) empties the needle, partial matches, position and output buffer;
// needle bytes themselves are not cleared and need no clearing pass.
// Top level: shift-and matcher as a chain of ssu_cell, control, and ssu_out_buf.
// Depends on ssu_pkg, ssu_cell and ssu_out_buf.
module substring_search_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // [0] mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] match_position
	output logic [1:0]  m_tuser    // [0] found, [1] needle_overflow
);
	import ssu_pkg::*;

	logic                accept;
	logic                is_nul;
	logic                closed_q;
	logic                ovf_q;
	logic                done_q;
	logic [LEN_W-1:0]    len_q;
	logic [POS_BITS-1:0] pos_q;
	logic [LEN_W-1:0]    eff_len;
	logic                eff_ovf;
	logic                hay_step;
	logic                hit_any;
	logic [NEEDLE_MAX-1:0] cell_hit;
	logic [NEEDLE_MAX:0]   pm_chain;
	logic [WIDE_W-1:0]   pos_w;
	logic [WIDE_W-1:0]   len_m1;
	logic [WIDE_W-1:0]   start_w;
	logic                push;
	ssu_result_t         push_data;
	ssu_result_t         out_data;
	ssu_ctrl_t           ctrl;

	assign accept  = s_tvalid & s_tready;
	assign is_nul  = (s_tdata == NUL_BYTE);

	// A needle byte after a closed needle starts a fresh needle.
	assign eff_len = closed_q ? '0 : len_q;
	assign eff_ovf = closed_q ? 1'b0 : ovf_q;

	// A haystack byte advances the matcher only while a search is open.
	assign hay_step = accept && (s_tuser == MODE_HAY) && !is_nul && !done_q &&
		(len_q != '0);

	// Broadcast control to the cell chain.
	always_comb begin
		ctrl.wr_en      = accept && (s_tuser == MODE_NEEDLE) && !is_nul &&
			(eff_len < LEN_W'(NEEDLE_MAX));
		ctrl.wr_idx     = eff_len;
		ctrl.step       = hay_step;
		ctrl.clr        = accept && ((s_tuser == MODE_NEEDLE) || is_nul);
		ctrl.needle_len = len_q;
		ctrl.data       = s_tdata;
	end

	// Chain of matcher cells; cell 0 always sees a held empty prefix.
	assign pm_chain[0] = 1'b1;
	for (genvar gi = 0; gi < NEEDLE_MAX; gi++) begin : g_cell
		ssu_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_idx (LEN_W'(gi)),
			.ctrl     (ctrl),
			.pm_in    (pm_chain[gi]),
			.pm_out   (pm_chain[gi+1]),
			.hit      (cell_hit[gi])
		);
	end
	assign hit_any = |cell_hit;

	// Match start: current position minus needle length less one.
	assign pos_w   = WIDE_W'(pos_q);
	assign len_m1  = WIDE_W'(len_q) - WIDE_W'(1);
	assign start_w = (pos_w >= len_m1) ? (pos_w - len_m1) : '0;

	// Result word selection.
	always_comb begin
		push            = 1'b0;
		push_data.found = 1'b0;
		push_data.pos   = '0;
		push_data.ovf   = ovf_q;
		if (accept && (s_tuser == MODE_HAY)) begin
			if (is_nul) begin
				push            = !done_q;
				push_data.found = (len_q == '0);
			end else if (!done_q && (len_q == '0)) begin
				push            = 1'b1;
				push_data.found = 1'b1;
			end else if (hay_step && hit_any) begin
				push            = 1'b1;
				push_data.found = 1'b1;
				push_data.pos   = MATCH_POS_W'(start_w);
			end
		end
	end

	// Needle and search control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q    <= '0;
			closed_q <= 1'b0;
			ovf_q    <= 1'b0;
			done_q   <= 1'b0;
			pos_q    <= '0;
		end else if (accept) begin
			if (s_tuser == MODE_NEEDLE) begin
				pos_q  <= '0;
				done_q <= 1'b0;
				if (is_nul) begin
					closed_q <= 1'b1;
					len_q    <= eff_len;
					ovf_q    <= eff_ovf;
				end else if (eff_len < LEN_W'(NEEDLE_MAX)) begin
					closed_q <= 1'b0;
					len_q    <= eff_len + LEN_W'(1);
					ovf_q    <= eff_ovf;
				end else begin
					closed_q <= 1'b0;
					len_q    <= eff_len;
					ovf_q    <= 1'b1;
				end
			end else begin
				closed_q <= 1'b1;
				if (is_nul) begin
					pos_q  <= '0;
					done_q <= 1'b0;
				end else if (!done_q) begin
					if (len_q == '0) begin
						done_q <= 1'b1;
					end else begin
						if (pos_q != '1) begin
							pos_q <= pos_q + POS_BITS'(1);
						end
						if (hit_any) begin
							done_q <= 1'b1;
						end
					end
				end
			end
		end
	end

	// Output buffer between the matcher and the master side.
	ssu_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_data)
	);

	assign m_tdata    = out_data.pos;
	assign m_tuser[0] = out_data.found;
	assign m_tuser[1] = out_data.ovf;

	// The stored needle never grows past its capacity.
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_W'(NEEDLE_MAX))
		else $error("needle length beyond capacity");

	// A found word closes the search until the terminator.
	a_done_after_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(push && push_data.found && !is_nul) |=> done_q)
		else $error("search still open after a match");

	// No word is produced while a search is already finished, not even at the terminator.
	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		(push && done_q) |-> 1'b0)
		else $error("second result for one haystack");

endmodule

// ===== hdl/ssu_cell.sv =====
`timescale 1ns / 1ps
// One cell of the shift-and matcher: holds one needle byte and one partial-match bit.
// Depends on ssu_pkg for the control struct and widths.
module ssu_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [ssu_pkg::LEN_W-1:0] cell_idx,
	input  ssu_pkg::ssu_ctrl_t        ctrl,
	input  logic                      pm_in,
	output logic                      pm_out,
	output logic                      hit
);
	import ssu_pkg::*;

	logic [BYTE_W-1:0] nb_q;
	logic              pm_q;
	logic              pm_next;
	logic              is_last;

	// Prefix ending here extends if the previous prefix held and this byte matches.
	assign pm_next = pm_in & (nb_q == ctrl.data);
	assign is_last = (ctrl.needle_len == (cell_idx + LEN_W'(1)));
	assign hit     = pm_next & is_last;
	assign pm_out  = pm_q;

	// Needle byte store, written once per append.
	always_ff @(posedge clk) begin
		if (ctrl.wr_en && (ctrl.wr_idx == cell_idx)) begin
			nb_q <= ctrl.data;
		end
	end

	// Partial-match bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pm_q <= 1'b0;
		end else if (ctrl.clr) begin
			pm_q <= 1'b0;
		end else if (ctrl.step) begin
			pm_q <= pm_next;
		end
	end

endmodule

// ===== hdl/ssu_out_buf.sv =====
`timescale 1ns / 1ps
// Two-entry output buffer (output register plus skid stage) for result words.
// Depends on ssu_pkg for the result struct.
module ssu_out_buf (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  ssu_pkg::ssu_result_t push_data,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	output ssu_pkg::ssu_result_t out_data
);
	import ssu_pkg::*;

	logic        out_v_q;
	logic        skid_v_q;
	ssu_result_t out_d_q;
	ssu_result_t skid_d_q;
	logic        pop;

	assign pop       = out_v_q & out_ready;
	assign out_valid = out_v_q;
	assign out_data  = out_d_q;
	assign in_ready  = !skid_v_q;

	// Valid flags of both entries.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (pop) begin
			out_v_q  <= skid_v_q | push;
			skid_v_q <= skid_v_q & push;
		end else if (out_v_q) begin
			skid_v_q <= skid_v_q | push;
		end else begin
			out_v_q  <= push;
		end
	end

	// Payload of both entries; the older word always sits in the output register.
	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_v_q) begin
				out_d_q <= skid_d_q;
				if (push) begin
					skid_d_q <= push_data;
				end
			end else if (push) begin
				out_d_q <= push_data;
			end
		end else if (out_v_q) begin
			if (push && !skid_v_q) begin
				skid_d_q <= push_data;
			end
		end else if (push) begin
			out_d_q <= push_data;
		end
	end

	// A word is never pushed while both entries are taken.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !skid_v_q)
		else $error("result pushed into a full output buffer");

	// The skid entry is only used behind a valid output register.
	a_skid_order: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid entry valid while output register empty");

endmodule

// ===== tb/substring_search_checker.sv =====
`timescale 1ns / 1ps
// Checker for substring_search_unit: watches both stream channels, predicts each result word
// and compares it with what the block delivers. Depends on ssu_pkg.
module substring_search_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // [0] mode
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,   // [31:0] match_position
	input  logic [1:0]  m_tuser,   // [0] found, [1] needle_overflow
	output int          fail_count,
	output int          pending
);
	import ssu_pkg::*;

	// Predicted search state.
	logic [BYTE_W-1:0]   needle_bytes [NEEDLE_MAX];
	int unsigned         needle_len  = 0;
	bit                  needle_shut = 0;
	bit                  needle_cut  = 0;
	logic [NEEDLE_MAX-1:0] prefix_hits = '0;
	logic [POS_BITS-1:0] hay_pos     = '0;
	bit                  hay_matched = 0;

	ssu_result_t results_due [$];
	ssu_result_t want;
	int          errors = 0;

	// Queue one result word.
	task automatic push_result(input bit hit, input logic [POS_BITS-1:0] start);
		ssu_result_t r;
		r.found = hit;
		r.pos   = hit ? MATCH_POS_W'(start) : '0;
		r.ovf   = needle_cut;
		results_due.push_back(r);
	endtask

	// Apply one accepted input word to the predicted state.
	task automatic advance_search(input logic mode, input logic [BYTE_W-1:0] c);
		int                  i;
		logic [POS_BITS-1:0] at_pos;
		logic [POS_BITS-1:0] start;
		if (mode == MODE_NEEDLE) begin
			// Any needle word drops a haystack in progress.
			prefix_hits = '0;
			hay_pos     = '0;
			hay_matched = 0;
			if (needle_shut) begin
				needle_shut = 0;
				needle_len  = 0;
				needle_cut  = 0;
			end
			if (c == NUL_BYTE) begin
				needle_shut = 1;
			end else if (needle_len < NEEDLE_MAX) begin
				needle_bytes[needle_len] = c;
				needle_len++;
			end else begin
				needle_cut = 1;
			end
		end else begin
			needle_shut = 1;
			if (c == NUL_BYTE) begin
				if (!hay_matched)
					push_result(needle_len == 0, '0);
				prefix_hits = '0;
				hay_pos     = '0;
				hay_matched = 0;
			end else if (!hay_matched) begin
				if (needle_len == 0) begin
					hay_matched = 1;
					push_result(1, '0);
				end else begin
					// Shift-and over the prefixes that are in use.
					for (i = needle_len - 1; i > 0; i--)
						prefix_hits[i] = prefix_hits[i-1] && (needle_bytes[i] == c);
					prefix_hits[0] = (needle_bytes[0] == c);
					at_pos = hay_pos;
					if (hay_pos != '1)
						hay_pos++;
					if (prefix_hits[needle_len-1]) begin
						start = (at_pos >= POS_BITS'(needle_len - 1)) ?
							at_pos - POS_BITS'(needle_len - 1) : '0;
						hay_matched = 1;
						push_result(1, start);
					end
				end
			end
		end
	endtask

	// Compare delivered words first; a word never depends on the input taken at the same edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			needle_len  = 0;
			needle_shut = 0;
			needle_cut  = 0;
			prefix_hits = '0;
			hay_pos     = '0;
			hay_matched = 0;
			results_due.delete();
			pending    <= 0;
			fail_count <= errors;
		end else begin
			if (m_tvalid && m_tready) begin
				if (results_due.size() == 0) begin
					if (errors < 10)
						$display("%0t: unexpected word found=%0b pos=%0d ovf=%0b",
							$time, m_tuser[0], m_tdata, m_tuser[1]);
					errors++;
				end else begin
					want = results_due.pop_front();
					if (m_tuser[0] !== want.found || m_tdata !== want.pos ||
							m_tuser[1] !== want.ovf) begin
						if (errors < 10) begin
							$display("%0t: mismatch expected found=%0b pos=%0d ovf=%0b",
								$time, want.found, want.pos, want.ovf);
							$display("%0t: mismatch actual   found=%0b pos=%0d ovf=%0b",
								$time, m_tuser[0], m_tdata, m_tuser[1]);
						end
						errors++;
					end
				end
			end
			if (s_tvalid && s_tready)
				advance_search(s_tuser, s_tdata);
			pending    <= results_due.size();
			fail_count <= errors;
		end
	end

endmodule

// ===== tb/substring_search_unit_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for substring_search_unit: drives needle and haystack words, paces the
// result consumer and gives the verdict. Depends on ssu_pkg and substring_search_checker.
module substring_search_unit_tb;
	import ssu_pkg::*;

	localparam int ITEMS       = 1750;
	localparam int HOLD_CYCLES = 300;
	localparam int STALL_LIMIT = 2000;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] data_byte
	logic        s_tuser;   // [0] mode
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // [31:0] match_position
	logic [1:0]  m_tuser;   // [0] found, [1] needle_overflow
	int          fail_count;
	int          pending;

	int words_sent = 0;
	bit idle_on    = 0;
	bit hold_req   = 0;
	bit paused     = 0;
	int stuck      = 0;

	substring_search_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	substring_search_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Offer one word, with an occasional gap in front of it.
	task automatic send_word(input logic mode, input logic [7:0] value);
		if (idle_on && $urandom_range(0, 7) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= value;
		do @(posedge clk); while (!s_tready);
		words_sent++;
	endtask

	// A narrow alphabet makes partial and full matches frequent.
	function automatic logic [7:0] pick_byte(input bit narrow);
		return narrow ? 8'($urandom_range(1, 3)) : 8'($urandom_range(1, 255));
	endfunction

	// One needle followed by a few haystacks, some holding the needle.
	task automatic run_search_round(input bit force_long);
		logic [7:0] needle [$];
		logic [7:0] hay [$];
		int         nlen;
		int         hlen;
		int         at;
		bit         narrow;
		narrow = 1'($urandom_range(0, 1));
		if (force_long || $urandom_range(0, 15) == 0)
			nlen = $urandom_range(NEEDLE_MAX - 4, NEEDLE_MAX + 8);
		else
			nlen = $urandom_range(0, 6);
		repeat (nlen) needle.push_back(pick_byte(narrow));
		foreach (needle[i]) send_word(MODE_NEEDLE, needle[i]);
		// Sometimes the first haystack word has to close the needle.
		if ($urandom_range(0, 7) != 0)
			send_word(MODE_NEEDLE, NUL_BYTE);
		repeat ($urandom_range(1, 3)) begin
			hay.delete();
			hlen = $urandom_range(0, 24);
			repeat (hlen) hay.push_back(pick_byte(narrow));
			if (nlen > 0 && $urandom_range(0, 1) == 1) begin
				at = $urandom_range(0, hlen);
				for (int k = nlen - 1; k >= 0; k--)
					hay.insert(at, needle[k]);
			end
			foreach (hay[i]) send_word(MODE_HAY, hay[i]);
			// A missing terminator leaves the haystack to be abandoned.
			if ($urandom_range(0, 9) != 0)
				send_word(MODE_HAY, NUL_BYTE);
		end
	endtask

	// Unstructured words of either kind.
	task automatic send_noise();
		repeat ($urandom_range(1, 8))
			send_word($urandom_range(0, 1) ? MODE_HAY : MODE_NEEDLE,
				($urandom_range(0, 3) == 0) ? NUL_BYTE : 8'($urandom_range(0, 255)));
	endtask

	// Result consumer: random stalls and one long hold-off.
	initial begin
		bit hold_done;
		hold_done = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				m_tready <= 1'b1;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Watchdog on cycles with no word moving on either side.
	initial begin
		while (stuck < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
				stuck = 0;
			else
				stuck++;
		end
		$display("substring_search_unit_tb: FAIL");
		$finish;
	end

	// Stimulus and verdict.
	initial begin
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tuser  <= MODE_NEEDLE;
		s_tdata  <= NUL_BYTE;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty needle out of reset, then a terminator first.
		send_word(MODE_HAY, NUL_BYTE);
		// Needle with extreme bytes, found at position one.
		send_word(MODE_NEEDLE, 8'h61);
		send_word(MODE_NEEDLE, 8'hFF);
		send_word(MODE_NEEDLE, 8'h01);
		send_word(MODE_NEEDLE, NUL_BYTE);
		send_word(MODE_HAY, 8'h61);
		send_word(MODE_HAY, 8'h61);
		send_word(MODE_HAY, 8'hFF);
		send_word(MODE_HAY, 8'h01);
		// Bytes after a match are ignored; the terminator stays silent.
		send_word(MODE_HAY, 8'h22);
		send_word(MODE_HAY, NUL_BYTE);
		// Same needle, not found.
		send_word(MODE_HAY, 8'h80);
		send_word(MODE_HAY, NUL_BYTE);
		// Haystack abandoned by a new needle that the haystack itself closes.
		send_word(MODE_HAY, 8'h61);
		send_word(MODE_NEEDLE, 8'h80);
		send_word(MODE_NEEDLE, 8'h7F);
		send_word(MODE_HAY, 8'h80);
		send_word(MODE_HAY, 8'h7F);
		send_word(MODE_HAY, NUL_BYTE);
		// Fresh empty needle matches on the first haystack byte.
		send_word(MODE_NEEDLE, NUL_BYTE);
		send_word(MODE_HAY, 8'h55);
		send_word(MODE_HAY, NUL_BYTE);

		// Random part, opened by a long needle that may overflow.
		idle_on = 1;
		run_search_round(1);
		while (words_sent < ITEMS) begin
			idle_on = (words_sent < ITEMS - 300) && ($urandom_range(0, 3) != 0);
			if (!hold_req && words_sent >= 600) begin
				hold_req = 1;
				idle_on  = 0;
			end
			if (!paused && words_sent >= 1100) begin
				paused = 1;
				s_tvalid <= 1'b0;
				do @(posedge clk); while (pending != 0);
			end
			if ($urandom_range(0, 6) == 0)
				send_noise();
			else
				run_search_round(0);
		end
		idle_on = 0;
		s_tvalid <= 1'b0;

		// Drain and let any stray word show up.
		do @(posedge clk); while (pending != 0);
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("substring_search_unit_tb: PASS");
		else
			$display("substring_search_unit_tb: FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/ssu_pkg.sv
hdl/ssu_cell.sv
hdl/ssu_out_buf.sv
hdl/substring_search_unit.sv
tb/substring_search_checker.sv
tb/substring_search_unit_tb.sv
